// ----- hdl/bounded_list_sort_engine_unit_macros.svh -----
// Assertion helpers shared by the sort engine RTL.
`ifndef BOUNDED_LIST_SORT_ENGINE_UNIT_MACROS_SVH
`define BOUNDED_LIST_SORT_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is asserted
`define BLSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that must also hold during reset
`define BLSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BLSE_ASSERT(label, prop, msg)
`define BLSE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- hdl/blse_pkg.sv -----
`timescale 1ns / 1ps

package blse_pkg;

    // Number of entries in the sorting chain
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Engine phases
    typedef enum logic [0:0] {
        ST_COLLECT = 1'b0,
        ST_DRAIN   = 1'b1
    } blse_state_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic insert;      // place new value into the chain
        logic shift;       // move chain one place toward the head
        logic descending;  // ordering sense
    } blse_ctrl_t;

endpackage

// ----- hdl/blse_cell.sv -----
`timescale 1ns / 1ps

module blse_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blse_pkg::blse_ctrl_t              ctrl,
    input  logic signed [blse_pkg::DATA_W-1:0] new_value,
    input  logic                              left_take,
    input  logic signed [blse_pkg::DATA_W-1:0] left_value,
    input  logic                              left_valid,
    input  logic signed [blse_pkg::DATA_W-1:0] right_value,
    input  logic                              right_valid,
    output logic                              take,
    output logic signed [blse_pkg::DATA_W-1:0] value,
    output logic                              valid
);
    import blse_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     valid_reg, valid_next;
    logic                     goes_before;

    // New value belongs ahead of the held one (empty cells take anything)
    always_comb
    begin
        if (ctrl.descending)
        begin
            goes_before = new_value > value_reg;
        end
        else
        begin
            goes_before = new_value < value_reg;
        end
        take = !valid_reg || goes_before;
    end

    // Insert: take left neighbor's value if it moved, else new value if it fits here
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (left_take)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (take)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    // Payload holds no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- hdl/bounded_list_sort_engine_unit.sv -----
`timescale 1ns / 1ps
`include "bounded_list_sort_engine_unit_macros.svh"

// Bounded sort engine. Values stream in on the slave side, one beat per cycle,
// and drop straight into their sorted place in a chain of 64 cells: every cell
// compares the new value with its own and either keeps, takes it, or takes its
// left neighbor's value. The beat with tlast closes the set; the chain then
// shifts toward its head one place per accepted master beat. The slave side is
// not ready while a set drains. Values arriving once 64 are held are
// discarded and every output beat of that set carries tuser = 1.
// cfg_wr_data = 1 selects descending order; write it only while the engine is
// idle.
module bounded_list_sort_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,   // [0] descending
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [blse_pkg::DATA_W-1:0] s_tdata,       // [31:0] value
    input  logic                        s_tlast,       // last of set
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [blse_pkg::DATA_W-1:0] m_tdata,       // [31:0] sorted_value
    output logic                        m_tlast,       // end_of_set
    output logic                        m_tuser        // [0] dropped
);
    import blse_pkg::*;

    blse_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 overflow_reg, overflow_next;
    logic                 descending_reg;
    blse_ctrl_t           ctrl;
    logic                 s_beat, m_beat, full;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_valid [CAPACITY];
    logic                     cell_take  [CAPACITY];

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;
    assign full   = count_reg == CNT_W'(CAPACITY);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            descending_reg <= cfg_wr_data;
        end
    end

    // Phase control, fill count and drop flag
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        ctrl.insert     = 1'b0;
        ctrl.shift      = 1'b0;
        ctrl.descending = descending_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                s_tready = 1'b1;
                if (s_beat)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                m_tvalid = 1'b1;
                if (m_beat)
                begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        overflow_next = 1'b0;
                        state_next    = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Sorting chain
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     l_take;
            logic signed [DATA_W-1:0] l_value;
            logic                     l_valid;
            logic signed [DATA_W-1:0] r_value;
            logic                     r_valid;

            if (i == 0)
            begin : g_head
                assign l_take  = 1'b0;
                assign l_value = '0;
                assign l_valid = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_take  = cell_take[i-1];
                assign l_value = cell_value[i-1];
                assign l_valid = cell_valid[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_value = cell_value[i+1];
                assign r_valid = cell_valid[i+1];
            end

            blse_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   ($signed(s_tdata)),
                .left_take   (l_take),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .right_value (r_value),
                .right_valid (r_valid),
                .take        (cell_take[i]),
                .value       (cell_value[i]),
                .valid       (cell_valid[i])
            );
        end
    endgenerate

    // Head of chain is the output register
    assign m_tdata = cell_value[0];
    assign m_tlast = count_reg == CNT_W'(1);
    assign m_tuser = overflow_reg;

    `BLSE_ASSERT(a_one_side, !(s_tready && m_tvalid), "both sides open at once")
    `BLSE_ASSERT(a_head_valid, m_tvalid |-> (cell_valid[0] && count_reg != '0),
        "draining with empty chain")
    `BLSE_ASSERT(a_last_drains, (s_beat && s_tlast) |=> m_tvalid, "set end did not start drain")
    `BLSE_ASSERT(a_end_reopens, (m_beat && m_tlast) |=> (s_tready && count_reg == '0),
        "engine not idle after set end")
    `BLSE_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "fill count beyond capacity")

endmodule
